// ===== hw/rtl/syslog_payload_classifier_defines.svh =====
// Assertion macros used by the checker file.
`ifndef SYSLOG_PAYLOAD_CLASSIFIER_DEFINES_SVH
`define SYSLOG_PAYLOAD_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define SPC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define SPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/spc_pkg.sv =====
`default_nettype none

package spc_pkg;

	// Port widths
	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 8;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// Characters the parser looks for
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;

	// Body prefixes and month table
	localparam logic [3:0] PFX_LAST_LEN = 4'd12;
	localparam logic [3:0] PFX_TOOL_LEN = 4'd7;
	localparam int unsigned NUM_MONTHS  = 12;

	// Header status handed from the header tracker to the body rules
	typedef struct packed {
		logic first;    // first byte of a payload
		logic in_body;  // this byte belongs to the message body
		logic alive;    // header is complete and valid up to this byte
	} hdr_stat_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
	endfunction

	function automatic logic is_delim(input logic [7:0] c);
		return c inside {CH_SP, CH_COLON, CH_EQ, CH_LBRK, CH_DASH};
	endfunction

	// "last message"
	function automatic logic [7:0] pfx_last_char(input logic [3:0] k);
		logic [7:0] c;
		case (k)
			4'd0: c = "l";
			4'd1: c = "a";
			4'd2: c = "s";
			4'd3: c = "t";
			4'd4: c = " ";
			4'd5: c = "m";
			4'd6: c = "e";
			4'd7: c = "s";
			4'd8: c = "s";
			4'd9: c = "a";
			4'd10: c = "g";
			4'd11: c = "e";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Alert tool prefix, seven bytes ending in colon and space
	function automatic logic [7:0] pfx_tool_char(input logic [2:0] k);
		logic [7:0] c;
		case (k)
			3'd0: c = 8'h73;
			3'd1: c = 8'h6E;
			3'd2: c = 8'h6F;
			3'd3: c = 8'h72;
			3'd4: c = 8'h74;
			3'd5: c = 8'h3A;
			3'd6: c = 8'h20;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Month abbreviations, first character in the top byte
	function automatic logic [23:0] month_name(input logic [3:0] m);
		logic [23:0] n;
		case (m)
			4'd0: n = "Jan";
			4'd1: n = "Feb";
			4'd2: n = "Mar";
			4'd3: n = "Apr";
			4'd4: n = "May";
			4'd5: n = "Jun";
			4'd6: n = "Jul";
			4'd7: n = "Aug";
			4'd8: n = "Sep";
			4'd9: n = "Oct";
			4'd10: n = "Nov";
			4'd11: n = "Dec";
			default: n = 24'h0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/spc_header.sv =====
`default_nettype none

// Tracks the "<PRI>" header and the optional space behind it.
module spc_header (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              last,
	input  logic [7:0]        data_byte,
	output spc_pkg::hdr_stat_t hdr
);
	import spc_pkg::*;

	localparam logic [2:0] PH_OPEN  = 3'd0;
	localparam logic [2:0] PH_PRI   = 3'd1;
	localparam logic [2:0] PH_SPACE = 3'd2;
	localparam logic [2:0] PH_BODY  = 3'd3;
	localparam logic [2:0] PH_FAIL  = 3'd4;

	logic [2:0] phase_q, phase_n;
	logic [1:0] pri_cnt_q, pri_cnt_n;

	// Header decode for the current byte
	always_comb begin
		phase_n   = phase_q;
		pri_cnt_n = pri_cnt_q;
		hdr       = '0;
		case (phase_q)
			PH_OPEN: begin
				hdr.first = 1'b1;
				pri_cnt_n = 2'd0;
				phase_n   = (data_byte == CH_LT) ? PH_PRI : PH_FAIL;
			end
			PH_PRI: begin
				if (data_byte == CH_GT) begin
					phase_n   = PH_SPACE;
					hdr.alive = 1'b1;
				end else if (is_digit(data_byte) && pri_cnt_q != 2'd3) begin
					pri_cnt_n = pri_cnt_q + 2'd1;
				end else begin
					phase_n = PH_FAIL;
				end
			end
			PH_SPACE: begin
				// a non-space here is already the first body byte
				hdr.alive   = 1'b1;
				hdr.in_body = (data_byte != CH_SP);
				phase_n     = PH_BODY;
			end
			PH_BODY: begin
				hdr.alive   = 1'b1;
				hdr.in_body = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_OPEN;
			pri_cnt_q <= 2'd0;
		end else if (adv) begin
			phase_q   <= last ? PH_OPEN : phase_n;
			pri_cnt_q <= pri_cnt_n;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/spc_body.sv =====
`default_nettype none

// Body rules: prefixes, version/year, month name and the hostname walk.
// All rules run side by side on the byte stream, offsets counted from body start.
module spc_body (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               last,
	input  logic [7:0]         data_byte,
	input  spc_pkg::hdr_stat_t hdr,
	output logic               body_one
);
	import spc_pkg::*;

	localparam logic [2:0] H_WAIT  = 3'd0;
	localparam logic [2:0] H_SPACE = 3'd1;
	localparam logic [2:0] H_WALK  = 3'd2;
	localparam logic [2:0] H_COLON = 3'd3;
	localparam logic [2:0] H_ONE   = 3'd4;
	localparam logic [2:0] H_PORT  = 3'd5;

	localparam logic [1:0] MS_WAIT   = 2'd0;
	localparam logic [1:0] MS_SECOND = 2'd1;
	localparam logic [1:0] MS_THIRD  = 2'd2;
	localparam logic [1:0] MS_DONE   = 2'd3;

	logic [3:0]            k_q;
	logic                  last_ok_q, tool_ok_q, year_ok_q, hit_q;
	logic [1:0]            mon_st_q, mon_st_n;
	logic [NUM_MONTHS-1:0] mon_mask_q, mon_mask_n;
	logic [2:0]            host_q, host_n;

	logic                  last_m, tool_m, year_n, hit_year, hit_mon, at_j, host_one;
	logic                  alnum, hit_now;
	logic [NUM_MONTHS-1:0] mon_c0, mon_c1, mon_c2;

	// Per-month character compares
	for (genvar g = 0; g < NUM_MONTHS; g++) begin : g_month
		localparam logic [23:0] NAME = month_name(4'(g));
		assign mon_c0[g] = (data_byte == NAME[23:16]);
		assign mon_c1[g] = (data_byte == NAME[15:8]);
		assign mon_c2[g] = (data_byte == NAME[7:0]);
	end

	// Prefix and version/year matching; at_j marks where month and hostname start
	always_comb begin
		alnum    = is_alnum(data_byte);
		last_m   = last_ok_q && (k_q < PFX_LAST_LEN) && (data_byte == pfx_last_char(k_q));
		tool_m   = tool_ok_q && (k_q < PFX_TOOL_LEN) &&
		           (data_byte == pfx_tool_char(k_q[2:0]));
		year_n   = 1'b0;
		hit_year = 1'b0;
		at_j     = 1'b0;
		case (k_q)
			4'd0: begin
				year_n = (data_byte == CH_ONE);
				at_j   = (data_byte != CH_ONE);
			end
			4'd1: begin
				year_n = year_ok_q && (data_byte == CH_SP);
				at_j   = year_ok_q && (data_byte != CH_SP);
			end
			4'd2: begin
				year_n = year_ok_q && (data_byte inside {CH_ONE, CH_TWO});
				at_j   = year_ok_q;
			end
			4'd3, 4'd4: year_n = year_ok_q && is_digit(data_byte);
			4'd5: hit_year = year_ok_q && is_digit(data_byte);
			default: ;
		endcase
	end

	// Month name, three bytes from at_j
	always_comb begin
		mon_mask_n = mon_mask_q;
		mon_st_n   = mon_st_q;
		hit_mon    = 1'b0;
		case (mon_st_q)
			MS_WAIT: begin
				if (at_j) begin
					mon_mask_n = mon_c0;
					mon_st_n   = MS_SECOND;
				end
			end
			MS_SECOND: begin
				mon_mask_n = mon_mask_q & mon_c1;
				mon_st_n   = MS_THIRD;
			end
			MS_THIRD: begin
				hit_mon  = |(mon_mask_q & mon_c2);
				mon_st_n = MS_DONE;
			end
			default: ;
		endcase
	end

	// Hostname walk; host_one is the walk outcome if the payload ends on this byte
	always_comb begin
		host_n   = host_q;
		host_one = 1'b0;
		case (host_q)
			H_WAIT: begin
				if (at_j) begin
					if (alnum) begin
						host_n   = H_WALK;
						host_one = 1'b1;
					end else if (data_byte == CH_SP) begin
						host_n = H_SPACE;
					end else begin
						host_n = H_PORT;
					end
				end
			end
			H_SPACE: begin
				if (alnum) begin
					host_n   = H_WALK;
					host_one = 1'b1;
				end else begin
					host_n = H_PORT;
				end
			end
			H_WALK: begin
				if (alnum) begin
					host_one = 1'b1;
				end else begin
					// stop byte as the final byte: only a colon falls back
					host_one = (data_byte != CH_COLON);
					if (!is_delim(data_byte))
						host_n = H_PORT;
					else if (data_byte == CH_COLON)
						host_n = H_COLON;
					else
						host_n = H_ONE;
				end
			end
			H_COLON: begin
				if (data_byte == CH_SP) begin
					host_n   = H_ONE;
					host_one = 1'b1;
				end else begin
					host_n = H_PORT;
				end
			end
			H_ONE: host_one = 1'b1;
			default: ;
		endcase
	end

	assign hit_now  = (last_m && k_q == PFX_LAST_LEN - 4'd1) ||
	                  (tool_m && k_q == PFX_TOOL_LEN - 4'd1) || hit_year || hit_mon;
	assign body_one = hdr.in_body && (hit_q || hit_now || host_one);

	// Body tracking state; back to start outside the body and after a payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q        <= 4'd0;
			last_ok_q  <= 1'b1;
			tool_ok_q  <= 1'b1;
			year_ok_q  <= 1'b0;
			hit_q      <= 1'b0;
			mon_st_q   <= MS_WAIT;
			mon_mask_q <= '0;
			host_q     <= H_WAIT;
		end else if (adv) begin
			if (hdr.in_body && !last) begin
				k_q        <= (k_q == 4'hF) ? k_q : k_q + 4'd1;
				last_ok_q  <= last_m;
				tool_ok_q  <= tool_m;
				year_ok_q  <= year_n;
				hit_q      <= hit_q || hit_now;
				mon_st_q   <= mon_st_n;
				mon_mask_q <= mon_mask_n;
				host_q     <= host_n;
			end else begin
				k_q        <= 4'd0;
				last_ok_q  <= 1'b1;
				tool_ok_q  <= 1'b1;
				year_ok_q  <= 1'b0;
				hit_q      <= 1'b0;
				mon_st_q   <= MS_WAIT;
				mon_mask_q <= '0;
				host_q     <= H_WAIT;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/syslog_payload_classifier.sv =====
// Syslog payload classifier: one payload byte per request, one verdict per payload.
// Throughput: one byte per cycle while no result is blocked downstream, also across payload boundaries.
// A payload's last byte is accepted into the input register, and its verdict is then
// registered in the result register; the input stage stalls only while the result waits.
// Reset (arst_n low, asynchronous): both channels empty, parser at payload start,
// config back to min 20 / max 1024 / lenient port 514.
`default_nettype none

module syslog_payload_classifier (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [7:0] payload_byte, [23:8] source_port, [39:24] dest_port
	input  logic [spc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// [0] is_udp
	input  logic [0:0]                     s_axis_tuser,
	input  logic                           s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [0] is_syslog, [7:1] zero
	output logic [spc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                           cfg_wen,
	input  logic [spc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [spc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import spc_pkg::*;

	localparam int unsigned LEN_W = 11;
	localparam int unsigned PRT_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LENIENT_PORT = 2'd2;

	// Config registers
	logic [LEN_W-1:0] min_len_q, max_len_q;
	logic [PRT_W-1:0] lport_q;

	// Input stage
	logic             valid_s1, last_s1, udp_s1;
	logic [7:0]       byte_s1;
	logic [PRT_W-1:0] sport_s1, dport_s1;

	// Per-payload state
	logic [LEN_W-1:0] pos_q;
	logic             port_q;

	// Result register
	logic             out_valid_q, out_syslog_q;

	logic             adv, pos_sat, len_ok, port_hit, body_one, verdict;
	logic [LEN_W:0]   len_w;
	hdr_stat_t        hdr;

	// Input stage moves on unless it holds a last byte and the result is blocked
	assign adv           = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata[7:0];
			sport_s1 <= s_axis_tdata[23:8];
			dport_s1 <= s_axis_tdata[39:24];
			udp_s1   <= s_axis_tuser[0];
			last_s1  <= s_axis_tlast;
		end
	end

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= 11'd20;
			max_len_q <= 11'd1024;
			lport_q   <= 16'd514;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_MIN_LEN:      min_len_q <= cfg_wdata[LEN_W-1:0];
				REG_MAX_LEN:      max_len_q <= cfg_wdata[LEN_W-1:0];
				REG_LENIENT_PORT: lport_q   <= cfg_wdata[PRT_W-1:0];
				default: ;
			endcase
		end
	end

	spc_header u_header (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.last      (last_s1),
		.data_byte (byte_s1),
		.hdr       (hdr)
	);

	spc_body u_body (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.last      (last_s1),
		.data_byte (byte_s1),
		.hdr       (hdr),
		.body_one  (body_one)
	);

	// Length window; a saturated count means the payload is too long for any window
	assign pos_sat  = &pos_q;
	assign len_w    = {1'b0, pos_q} + {{LEN_W{1'b0}}, 1'b1};
	assign len_ok   = !pos_sat && (len_w > {1'b0, min_len_q}) && (len_w <= {1'b0, max_len_q});
	assign port_hit = udp_s1 && (sport_s1 == lport_q || dport_s1 == lport_q);
	assign verdict  = hdr.alive && len_ok && (body_one || port_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			port_q <= 1'b0;
		end else if (adv) begin
			if (last_s1)
				pos_q <= '0;
			else if (!pos_sat)
				pos_q <= pos_q + {{(LEN_W-1){1'b0}}, 1'b1};
			if (hdr.first)
				port_q <= port_hit;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv && last_s1)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1)
			out_syslog_q <= verdict;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_syslog_q};

endmodule

`default_nettype wire

// ===== hw/rtl/spc_checker.sv =====
`default_nettype none
`include "syslog_payload_classifier_defines.svh"

// Port-level checks on the classifier
module spc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           s_axis_tlast,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [spc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import spc_pkg::*;

	// A stalled result holds
	`SPC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

	// Input side never stalls unless a result is blocked downstream
	`SPC_ASSERT_IMPL(a_in_ready, m_axis_tready || !m_axis_tvalid, s_axis_tready, "input stalled with free output")

	// Only the verdict bit may be set
	`SPC_ASSERT_IMPL(a_out_pad, m_axis_tvalid, m_axis_tdata[OUT_DATA_W-1:1] == '0, "nonzero pad bits in result")

	// No result and no stalled last byte straight out of reset
	`SPC_ASSERT_IMPL(a_rst_empty, $rose(arst_n), !m_axis_tvalid && !(s_axis_tvalid && s_axis_tlast && !s_axis_tready), "result or stall right after reset")

endmodule

bind syslog_payload_classifier spc_checker u_spc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
